/* hdl/mhsc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mhsc_pkg;

   // Sample and CORDIC sizing
   localparam int SAMPLE_WIDTH = 16;
   localparam int CORDIC_STEPS = 16;
   localparam int TABLE_LEN    = 24;
   localparam int AXIS_W       = SAMPLE_WIDTH + 1;
   localparam int SCALE_SHIFT  = 60 - SAMPLE_WIDTH;
   localparam int CORDIC_W     = 64;
   localparam int STEP_W       = $clog2(CORDIC_STEPS);
   localparam int TAB_IDX_W    = $clog2(TABLE_LEN);

   // Angles in 1/25600 degree
   localparam int ANG_W      = 27;
   localparam int FRAC_BITS  = 8;
   localparam int HEAD_W     = 16;
   localparam int HSUM_W     = 17;

   // Register widths
   localparam int EPS_W      = 16;
   localparam int LIMIT_W    = 8;
   localparam int OFFSET_W   = 16;
   localparam int CMP_W      = (AXIS_W > EPS_W) ? AXIS_W : EPS_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_STALE_EPSILON  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STALE_LIMIT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADING_OFFSET = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SWAP_AXES      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT_X       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT_Y       = 3'd5;

   // Register reset values
   localparam logic [EPS_W-1:0]    EPS_RESET    = 16'd3;
   localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 8'd20;
   localparam logic [OFFSET_W-1:0] OFFSET_RESET = 16'd9000;

   localparam logic [LIMIT_W-1:0]  COUNT_MAX    = {LIMIT_W{1'b1}};

   // Turn constants
   localparam logic [OFFSET_W-1:0]     OFFSET_TURN     = OFFSET_W'(36000);
   localparam logic [HSUM_W-1:0]       HEAD_TURN       = HSUM_W'(36000);
   localparam logic [HSUM_W-1:0]       HEAD_TWO_TURNS  = HSUM_W'(72000);
   localparam logic signed [ANG_W-1:0] HALF_TURN_ANGLE = ANG_W'(18000 * 256);
   localparam logic signed [ANG_W-1:0] FULL_TURN_ANGLE = ANG_W'(36000 * 256);
   localparam logic signed [ANG_W-1:0] ROUND_HALF      = ANG_W'(128);

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] mag_x;
      logic signed [SAMPLE_WIDTH-1:0] mag_y;
      logic signed [SAMPLE_WIDTH-1:0] mag_z;
   } req_type;

   typedef struct packed {
      logic [HEAD_W-1:0] heading;
      logic              reinit_request;
   } rsp_type;

   typedef struct packed {
      logic [EPS_W-1:0]    stale_epsilon;
      logic [LIMIT_W-1:0]  stale_limit;
      logic [OFFSET_W-1:0] heading_offset;
      logic                swap_axes;
      logic                invert_x;
      logic                invert_y;
   } cfg_type;

   // One classified item on its way to the CORDIC
   typedef struct packed {
      logic signed [AXIS_W-1:0] hx;
      logic signed [AXIS_W-1:0] hy;
      logic                     reinit;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_ROTATE,
      BK_WRAP
   } back_state_type;

   // atan(2^-i) in 1/25600 degree
   function automatic logic signed [ANG_W-1:0] atan_angle(input logic [TAB_IDX_W-1:0] idx);
      logic signed [ANG_W-1:0] a;
      case (idx)
         5'd0:    a = ANG_W'(1152000);
         5'd1:    a = ANG_W'(680065);
         5'd2:    a = ANG_W'(359328);
         5'd3:    a = ANG_W'(182400);
         5'd4:    a = ANG_W'(91554);
         5'd5:    a = ANG_W'(45822);
         5'd6:    a = ANG_W'(22916);
         5'd7:    a = ANG_W'(11459);
         5'd8:    a = ANG_W'(5730);
         5'd9:    a = ANG_W'(2865);
         5'd10:   a = ANG_W'(1432);
         5'd11:   a = ANG_W'(716);
         5'd12:   a = ANG_W'(358);
         5'd13:   a = ANG_W'(179);
         5'd14:   a = ANG_W'(90);
         5'd15:   a = ANG_W'(45);
         5'd16:   a = ANG_W'(22);
         5'd17:   a = ANG_W'(11);
         5'd18:   a = ANG_W'(6);
         5'd19:   a = ANG_W'(3);
         5'd20:   a = ANG_W'(1);
         5'd21:   a = ANG_W'(1);
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

`default_nettype wire

/* hdl/mhsc_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module mhsc_queue (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       push,
   input  mhsc_pkg::job_type         push_data,
   input  wire                       pop,
   output mhsc_pkg::job_type         pop_data,
   output mhsc_pkg::queue_status_type status
);
   import mhsc_pkg::*;

   job_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_data     = entry_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* hdl/mhsc_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module mhsc_front (
   input  wire                        clock,
   input  wire                        reset,
   input  mhsc_pkg::cfg_type          cfg,
   input  wire                        req_valid,
   output logic                       req_stall,
   input  mhsc_pkg::req_type          req_payload,
   input  mhsc_pkg::queue_status_type q_status,
   output logic                       push,
   output mhsc_pkg::job_type          push_data
);
   import mhsc_pkg::*;

   logic                           has_prev_ff, has_prev_in;
   logic signed [SAMPLE_WIDTH-1:0] prev_x_ff, prev_x_in;
   logic signed [SAMPLE_WIDTH-1:0] prev_y_ff, prev_y_in;
   logic signed [SAMPLE_WIDTH-1:0] prev_z_ff, prev_z_in;
   logic [LIMIT_W-1:0]             count_ff, count_in;

   logic signed [AXIS_W-1:0] sx, sy, sz, dx, dy, dz, ax, ay;
   logic [AXIS_W-1:0]        abs_x, abs_y, abs_z;
   logic                     near_all;
   logic [LIMIT_W-1:0]       count_upd;
   logic                     limit_hit;

   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;

   // per-axis change against the held sample
   always_comb begin
      sx = AXIS_W'(req_payload.mag_x);
      sy = AXIS_W'(req_payload.mag_y);
      sz = AXIS_W'(req_payload.mag_z);
      dx = sx - AXIS_W'(prev_x_ff);
      dy = sy - AXIS_W'(prev_y_ff);
      dz = sz - AXIS_W'(prev_z_ff);
      abs_x = dx[AXIS_W-1] ? AXIS_W'(-dx) : AXIS_W'(dx);
      abs_y = dy[AXIS_W-1] ? AXIS_W'(-dy) : AXIS_W'(dy);
      abs_z = dz[AXIS_W-1] ? AXIS_W'(-dz) : AXIS_W'(dz);
      near_all = (CMP_W'(abs_x) < CMP_W'(cfg.stale_epsilon))
              && (CMP_W'(abs_y) < CMP_W'(cfg.stale_epsilon))
              && (CMP_W'(abs_z) < CMP_W'(cfg.stale_epsilon));
   end

   // stale counter, saturating
   always_comb begin
      count_upd = count_ff;
      if (has_prev_ff) begin
         if (near_all) begin
            count_upd = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;
         end else begin
            count_upd = '0;
         end
      end
      limit_hit = (count_upd >= cfg.stale_limit);
   end

   // held sample update; reaching the limit clears everything
   always_comb begin
      has_prev_in = has_prev_ff;
      prev_x_in   = prev_x_ff;
      prev_y_in   = prev_y_ff;
      prev_z_in   = prev_z_ff;
      count_in    = count_ff;
      if (push) begin
         has_prev_in = !limit_hit;
         prev_x_in   = limit_hit ? '0 : req_payload.mag_x;
         prev_y_in   = limit_hit ? '0 : req_payload.mag_y;
         prev_z_in   = limit_hit ? '0 : req_payload.mag_z;
         count_in    = limit_hit ? '0 : count_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         has_prev_ff <= 1'b0;
         prev_x_ff   <= '0;
         prev_y_ff   <= '0;
         prev_z_ff   <= '0;
         count_ff    <= '0;
      end else begin
         has_prev_ff <= has_prev_in;
         prev_x_ff   <= prev_x_in;
         prev_y_ff   <= prev_y_in;
         prev_z_ff   <= prev_z_in;
         count_ff    <= count_in;
      end
   end

   // axis mapping for the heading
   always_comb begin
      ax = cfg.swap_axes ? sy : sx;
      ay = cfg.swap_axes ? sx : sy;
      push_data.hx     = cfg.invert_x ? AXIS_W'(-ax) : ax;
      push_data.hy     = cfg.invert_y ? AXIS_W'(-ay) : ay;
      push_data.reinit = limit_hit;
   end

endmodule

`default_nettype wire

/* hdl/mhsc_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module mhsc_back (
   input  wire                        clock,
   input  wire                        reset,
   input  mhsc_pkg::cfg_type          cfg,
   input  mhsc_pkg::queue_status_type q_status,
   output logic                       pop,
   input  mhsc_pkg::job_type          pop_data,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output mhsc_pkg::rsp_type          rsp_payload
);
   import mhsc_pkg::*;

   back_state_type             state_ff, state_in;
   logic signed [CORDIC_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ANG_W-1:0]    ang_ff, ang_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic                       reinit_ff, reinit_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_type                    rsp_data_ff, rsp_data_in;

   logic                       rsp_load, rsp_free, last_step;
   logic signed [AXIS_W-1:0]   lx, ly;
   logic signed [CORDIC_W-1:0] x_load, y_load, x_rot, y_rot, sh_x, sh_y;
   logic signed [ANG_W-1:0]    ang_load, ang_rot, total, rounded;
   logic signed [ANG_W-1:0]    tab_angle;
   logic [OFFSET_W-1:0]        off_mod;
   logic [HSUM_W-1:0]          hsum, hwrap;

   assign rsp_free    = !rsp_valid_ff || !rsp_stall;
   assign last_step   = (step_ff == STEP_W'(CORDIC_STEPS - 1));
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE:   if (!q_status.empty) state_in = BK_ROTATE;
         BK_ROTATE: if (last_step) state_in = BK_WRAP;
         BK_WRAP:   if (rsp_free) state_in = BK_IDLE;
         default:   state_in = BK_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      pop      = 1'b0;
      rsp_load = 1'b0;
      case (state_ff)
         BK_IDLE:   pop = !q_status.empty;
         BK_ROTATE: pop = 1'b0;
         BK_WRAP:   rsp_load = rsp_free;
         default: begin
            pop      = 1'b0;
            rsp_load = 1'b0;
         end
      endcase
   end

   // fold the left half plane and scale up
   always_comb begin
      if (pop_data.hx[AXIS_W-1]) begin
         lx       = AXIS_W'(-pop_data.hx);
         ly       = AXIS_W'(-pop_data.hy);
         ang_load = HALF_TURN_ANGLE;
      end else begin
         lx       = pop_data.hx;
         ly       = pop_data.hy;
         ang_load = '0;
      end
      x_load = CORDIC_W'(lx) <<< SCALE_SHIFT;
      y_load = CORDIC_W'(ly) <<< SCALE_SHIFT;
   end

   // one vectoring step per cycle, floor shifts
   always_comb begin
      sh_x      = y_ff >>> step_ff;
      sh_y      = x_ff >>> step_ff;
      tab_angle = atan_angle(TAB_IDX_W'(step_ff));
      x_rot     = x_ff;
      y_rot     = y_ff;
      ang_rot   = ang_ff;
      if (!y_ff[CORDIC_W-1] && (y_ff != '0)) begin
         x_rot   = x_ff + sh_x;
         y_rot   = y_ff - sh_y;
         ang_rot = ang_ff + tab_angle;
      end else if (y_ff[CORDIC_W-1]) begin
         x_rot   = x_ff - sh_x;
         y_rot   = y_ff + sh_y;
         ang_rot = ang_ff - tab_angle;
      end
   end

   // add offset, round to hundredths, wrap into one turn
   always_comb begin
      off_mod = (cfg.heading_offset >= OFFSET_TURN) ? cfg.heading_offset - OFFSET_TURN
                                                    : cfg.heading_offset;
      total   = ang_ff + ANG_W'({off_mod, {FRAC_BITS{1'b0}}}) + FULL_TURN_ANGLE;
      rounded = total + ROUND_HALF;
      hsum    = rounded[FRAC_BITS +: HSUM_W];
      if (hsum >= HEAD_TWO_TURNS) begin
         hwrap = hsum - HEAD_TWO_TURNS;
      end else if (hsum >= HEAD_TURN) begin
         hwrap = hsum - HEAD_TURN;
      end else begin
         hwrap = hsum;
      end
   end

   // datapath next values
   always_comb begin
      x_in      = x_ff;
      y_in      = y_ff;
      ang_in    = ang_ff;
      step_in   = step_ff;
      reinit_in = reinit_ff;
      if (pop) begin
         x_in      = x_load;
         y_in      = y_load;
         ang_in    = ang_load;
         step_in   = '0;
         reinit_in = pop_data.reinit;
      end else if (state_ff == BK_ROTATE) begin
         x_in    = x_rot;
         y_in    = y_rot;
         ang_in  = ang_rot;
         step_in = step_ff + 1'b1;
      end
      rsp_data_in = rsp_data_ff;
      if (rsp_load) begin
         rsp_data_in.heading        = HEAD_W'(hwrap);
         rsp_data_in.reinit_request = reinit_ff;
      end
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      y_ff        <= y_in;
      ang_ff      <= ang_in;
      step_ff     <= step_in;
      reinit_ff   <= reinit_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

/* hdl/magnetometer_heading_stale_check.sv */
// Compass heading from a three-axis magnetometer, with stale-sample detection.
// Request channel (req_valid / req_stall / req_payload) takes one sample of
// mag_x, mag_y, mag_z; an item is taken when req_valid is high and req_stall
// low. Response channel (rsp_valid / rsp_stall / rsp_payload) returns one
// heading (hundredths of a degree, 0..35999) and reinit_request per sample.
// Register writes come on csr_valid / csr_ready / csr_index / csr_wdata and
// must only be made while no sample is in flight.
// The front part checks the sample against the held one in the accepting
// cycle and passes it through a two-entry queue to the back part, which runs
// a 16-step vectoring CORDIC, one step per cycle.
// The back part takes a new sample from the queue only once it has loaded the
// response for the last one into the output register.
// A stalled response is held in the output register; the back part then waits
// and the queue fills, after which req_stall rises.
// Synchronous reset restores register defaults, forgets the held sample,
// clears the stale count and empties the queue and output register.
`timescale 1ns / 1ps
`default_nettype none

module magnetometer_heading_stale_check (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  mhsc_pkg::req_type                   req_payload,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output mhsc_pkg::rsp_type                   rsp_payload,
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire [mhsc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire [mhsc_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import mhsc_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   queue_status_type q_status;
   job_type          push_data, pop_data;
   logic             push, pop;

   assign csr_ready = 1'b1;

   // register writes; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_STALE_EPSILON:  cfg_in.stale_epsilon  = EPS_W'(csr_wdata);
            CSR_STALE_LIMIT:    cfg_in.stale_limit    = csr_wdata[LIMIT_W-1:0];
            CSR_HEADING_OFFSET: cfg_in.heading_offset = OFFSET_W'(csr_wdata);
            CSR_SWAP_AXES:      cfg_in.swap_axes      = csr_wdata[0];
            CSR_INVERT_X:       cfg_in.invert_x       = csr_wdata[0];
            CSR_INVERT_Y:       cfg_in.invert_y       = csr_wdata[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stale_epsilon  <= EPS_RESET;
         cfg_ff.stale_limit    <= LIMIT_RESET;
         cfg_ff.heading_offset <= OFFSET_RESET;
         cfg_ff.swap_axes      <= 1'b0;
         cfg_ff.invert_x       <= 1'b0;
         cfg_ff.invert_y       <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mhsc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .q_status    (q_status),
      .push        (push),
      .push_data   (push_data)
   );

   mhsc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   mhsc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_status    (q_status),
      .pop         (pop),
      .pop_data    (pop_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // queue never written when full
   assert property (@(posedge clock) disable iff (reset) push |-> !q_status.full)
      else $error("item pushed into full queue");

   // queue never read when empty
   assert property (@(posedge clock) disable iff (reset) pop |-> !q_status.empty)
      else $error("item popped from empty queue");

   // heading always wrapped into one turn
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid |-> (rsp_payload.heading < HEAD_W'(36000)))
      else $error("heading out of range");

endmodule

`default_nettype wire
